// ----- hdl/stc_pkg.sv -----
`timescale 1ns / 1ps
// stc_pkg: shared types and constants of the scope trigger capture block
// no dependencies

package stc_pkg;

  localparam int WIDTH       = 320;
  localparam int POS_BITS    = 9;
  localparam int SAMPLE_BITS = 14;
  localparam int WAIT_BITS   = 24;
  localparam int COUNT_BITS  = 12;
  localparam int INDEX_BITS  = 3;
  localparam int DATA_BITS   = 24;

  localparam logic [POS_BITS-1:0]           POS_LAST  = POS_BITS'(WIDTH - 1);
  localparam logic [POS_BITS:0]             POS_SPAN  = (POS_BITS + 1)'(WIDTH);
  localparam logic [WAIT_BITS-1:0]          WAIT_MAX  = {WAIT_BITS{1'b1}};
  localparam logic signed [COUNT_BITS-1:0]  COUNT_MAX = COUNT_BITS'(2047);
  localparam logic signed [COUNT_BITS-1:0]  COUNT_END = COUNT_BITS'(WIDTH - 1);
  localparam logic signed [COUNT_BITS-1:0]  COUNT_NONE = '1;

  typedef enum logic [INDEX_BITS-1:0] {
    CFG_TRIGGER_X        = 3'd0,
    CFG_TRIGGER_LEVEL    = 3'd1,
    CFG_TRIGGER_PREF     = 3'd2,
    CFG_DISPLAY_MASK     = 3'd3,
    CFG_NO_TRIGGER_LIMIT = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CH_NONE = 2'd0,
    CH_A    = 2'd1,
    CH_B    = 2'd2,
    CH_C    = 2'd3
  } chan_t;

  typedef enum logic {
    FUNC_SAMPLE  = 1'b0,
    FUNC_RESTART = 1'b1
  } func_t;

  typedef struct packed {
    logic [POS_BITS-1:0]    trigger_x;
    logic [SAMPLE_BITS-1:0] trigger_level;
    logic [1:0]             trigger_pref;
    logic [2:0]             display_mask;
    logic [WAIT_BITS-1:0]   no_trigger_limit;
  } cfg_t;

  typedef struct packed {
    logic                   func;
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
    logic [SAMPLE_BITS-1:0] sample_c;
    logic                   display_busy;
    logic                   display_buf;
  } item_t;

  typedef struct packed {
    logic                         wr_en;
    logic                         wr_buf;
    logic [POS_BITS-1:0]          wr_pos;
    logic [SAMPLE_BITS-1:0]       wr_a;
    logic [SAMPLE_BITS-1:0]       wr_b;
    logic [SAMPLE_BITS-1:0]       wr_c;
    logic                         capturing_now;
    logic                         capture_buf;
    logic signed [COUNT_BITS-1:0] captured_count;
    logic [POS_BITS-1:0]          offset_buf0;
    logic [POS_BITS-1:0]          offset_buf1;
    logic                         no_trigger_swap;
  } result_t;

endpackage

// ----- hdl/stc_core.sv -----
`timescale 1ns / 1ps
// stc_core: capture state registers and the single-pass update for one item
// depends on stc_pkg

module stc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  stc_pkg::item_t   item,
  input  stc_pkg::cfg_t    cfg,
  output stc_pkg::result_t res
);

  logic                                  capture_active;
  logic                                  fill_buffer;
  logic [stc_pkg::POS_BITS-1:0]          write_position;
  logic [stc_pkg::WAIT_BITS-1:0]         waiting_samples;
  logic [stc_pkg::SAMPLE_BITS-1:0]       previous_trigger_sample;
  logic [stc_pkg::POS_BITS-1:0]          draw_offsets [2];
  logic signed [stc_pkg::COUNT_BITS-1:0] captured_counts [2];

  logic                                  capture_active_next;
  logic                                  fill_buffer_next;
  logic [stc_pkg::POS_BITS-1:0]          write_position_next;
  logic [stc_pkg::WAIT_BITS-1:0]         waiting_samples_next;
  logic [stc_pkg::SAMPLE_BITS-1:0]       previous_trigger_sample_next;
  logic [stc_pkg::POS_BITS-1:0]          draw_offsets_next [2];
  logic signed [stc_pkg::COUNT_BITS-1:0] captured_counts_next [2];

  stc_pkg::chan_t                  ch;
  logic [stc_pkg::SAMPLE_BITS-1:0] tsample;
  logic [stc_pkg::POS_BITS-1:0]    tx;
  logic                            start;
  logic                            wr;
  logic [stc_pkg::POS_BITS:0]      wrap_pos;

  // trigger channel choice
  always_comb begin
    if (cfg.trigger_pref == stc_pkg::CH_NONE) begin
      ch = stc_pkg::CH_NONE;
    end else if ((cfg.trigger_pref == stc_pkg::CH_C && cfg.display_mask[2]) ||
                 cfg.display_mask == 3'b100) begin
      ch = stc_pkg::CH_C;
    end else if ((cfg.trigger_pref == stc_pkg::CH_B || !cfg.display_mask[0]) &&
                 cfg.display_mask[1]) begin
      ch = stc_pkg::CH_B;
    end else begin
      ch = stc_pkg::CH_A;
    end
  end

  assign tsample = (ch == stc_pkg::CH_A) ? item.sample_a :
                   (ch == stc_pkg::CH_B) ? item.sample_b : item.sample_c;
  assign tx = (cfg.trigger_x > stc_pkg::POS_LAST) ? stc_pkg::POS_LAST : cfg.trigger_x;
  assign wrap_pos = {1'b0, write_position} + stc_pkg::POS_SPAN - {1'b0, tx};

  always_comb begin
    capture_active_next          = capture_active;
    fill_buffer_next             = fill_buffer;
    write_position_next          = write_position;
    waiting_samples_next         = waiting_samples;
    previous_trigger_sample_next = previous_trigger_sample;
    draw_offsets_next            = draw_offsets;
    captured_counts_next         = captured_counts;
    start                        = 1'b0;
    wr                           = 1'b0;
    res                          = '0;

    if (item.func == stc_pkg::FUNC_RESTART) begin
      capture_active_next          = 1'b0;
      write_position_next          = '0;
      waiting_samples_next         = '0;
      previous_trigger_sample_next = '0;
    end else begin
      start = !capture_active && (!item.display_busy || fill_buffer != item.display_buf) &&
              (ch == stc_pkg::CH_NONE ||
               (waiting_samples > {{(stc_pkg::WAIT_BITS - stc_pkg::POS_BITS){1'b0}}, tx} &&
                previous_trigger_sample < cfg.trigger_level &&
                tsample >= cfg.trigger_level));
      if (start) begin
        capture_active_next = 1'b1;
        if (ch == stc_pkg::CH_NONE) begin
          write_position_next               = '0;
          draw_offsets_next[fill_buffer]    = '0;
          captured_counts_next[fill_buffer] = stc_pkg::COUNT_NONE;
        end else begin
          draw_offsets_next[fill_buffer] = (write_position >= tx) ?
              (write_position - tx) : wrap_pos[stc_pkg::POS_BITS-1:0];
          captured_counts_next[fill_buffer] =
              $signed({{(stc_pkg::COUNT_BITS - stc_pkg::POS_BITS){1'b0}}, tx}) -
              stc_pkg::COUNT_BITS'(1);
        end
      end

      // buffer full
      if (capture_active_next &&
          captured_counts_next[fill_buffer] == stc_pkg::COUNT_END) begin
        fill_buffer_next     = ~fill_buffer;
        waiting_samples_next = '0;
        capture_active_next  = 1'b0;
      end

      wr = capture_active_next || !item.display_busy || fill_buffer_next != item.display_buf;
      if (wr) begin
        res.wr_en  = 1'b1;
        res.wr_buf = fill_buffer_next;
        res.wr_pos = write_position_next;
        res.wr_a   = item.sample_a;
        res.wr_b   = item.sample_b;
        res.wr_c   = item.sample_c;
        if (ch != stc_pkg::CH_NONE) begin
          previous_trigger_sample_next = tsample;
        end
        if (write_position_next >= stc_pkg::POS_LAST) begin
          write_position_next = '0;
        end else begin
          write_position_next = write_position_next + stc_pkg::POS_BITS'(1);
        end
        if (captured_counts_next[fill_buffer_next] < stc_pkg::COUNT_MAX) begin
          captured_counts_next[fill_buffer_next] =
              captured_counts_next[fill_buffer_next] + stc_pkg::COUNT_BITS'(1);
        end
        if (!capture_active_next) begin
          if (waiting_samples_next < stc_pkg::WAIT_MAX) begin
            waiting_samples_next = waiting_samples_next + stc_pkg::WAIT_BITS'(1);
          end
          // timeout swap, draw untriggered
          if (waiting_samples_next > cfg.no_trigger_limit && write_position_next == '0) begin
            fill_buffer_next                    = ~fill_buffer_next;
            waiting_samples_next                = '0;
            draw_offsets_next[fill_buffer_next] = '0;
            res.no_trigger_swap                 = 1'b1;
          end
        end
      end
    end

    res.capturing_now  = capture_active_next;
    res.capture_buf    = fill_buffer_next;
    res.captured_count = captured_counts_next[fill_buffer_next];
    res.offset_buf0    = draw_offsets_next[0];
    res.offset_buf1    = draw_offsets_next[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_active          <= 1'b0;
      fill_buffer             <= 1'b0;
      write_position          <= '0;
      waiting_samples         <= '0;
      previous_trigger_sample <= '0;
      draw_offsets[0]         <= '0;
      draw_offsets[1]         <= '0;
      captured_counts[0]      <= '0;
      captured_counts[1]      <= '0;
    end else if (step) begin
      capture_active          <= capture_active_next;
      fill_buffer             <= fill_buffer_next;
      write_position          <= write_position_next;
      waiting_samples         <= waiting_samples_next;
      previous_trigger_sample <= previous_trigger_sample_next;
      draw_offsets[0]         <= draw_offsets_next[0];
      draw_offsets[1]         <= draw_offsets_next[1];
      captured_counts[0]      <= captured_counts_next[0];
      captured_counts[1]      <= captured_counts_next[1];
    end
  end

endmodule

// ----- hdl/scope_trigger_capture_top.sv -----
`timescale 1ns / 1ps
// scope_trigger_capture_top: three-channel edge trigger capture with ping-pong buffers
// depends on stc_pkg and stc_core
//
//   port group   direction  handshake             payload
//   in           to block   in_valid / in_ready   func, sample_a/b/c, display_busy/buf
//   out          from block out_valid / out_ready wr_*, capturing_now ... no_trigger_swap
//   cfg          to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item per cycle while the result register has room; each result passes the
// input register, then the state update into the result register
// in_ready drops only while the result register is full and out_ready is low
// cfg_ready is always high; rst is synchronous and clears capture state, config registers and valid flags

module scope_trigger_capture_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  func,
  input  logic [stc_pkg::SAMPLE_BITS-1:0]       sample_a,
  input  logic [stc_pkg::SAMPLE_BITS-1:0]       sample_b,
  input  logic [stc_pkg::SAMPLE_BITS-1:0]       sample_c,
  input  logic                                  display_busy,
  input  logic                                  display_buf,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  wr_en,
  output logic                                  wr_buf,
  output logic [stc_pkg::POS_BITS-1:0]          wr_pos,
  output logic [stc_pkg::SAMPLE_BITS-1:0]       wr_a,
  output logic [stc_pkg::SAMPLE_BITS-1:0]       wr_b,
  output logic [stc_pkg::SAMPLE_BITS-1:0]       wr_c,
  output logic                                  capturing_now,
  output logic                                  capture_buf,
  output logic signed [stc_pkg::COUNT_BITS-1:0] captured_count,
  output logic [stc_pkg::POS_BITS-1:0]          offset_buf0,
  output logic [stc_pkg::POS_BITS-1:0]          offset_buf1,
  output logic                                  no_trigger_swap,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [stc_pkg::INDEX_BITS-1:0]        cfg_index,
  input  logic [stc_pkg::DATA_BITS-1:0]         cfg_data
);

  stc_pkg::cfg_t    cfg;
  stc_pkg::item_t   item;
  stc_pkg::result_t res;
  stc_pkg::result_t res_q;
  logic             item_valid;
  logic             step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_x        <= stc_pkg::POS_BITS'(160);
      cfg.trigger_level    <= stc_pkg::SAMPLE_BITS'(8192);
      cfg.trigger_pref     <= stc_pkg::CH_A;
      cfg.display_mask     <= 3'b111;
      cfg.no_trigger_limit <= stc_pkg::WAIT_BITS'(20000);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        stc_pkg::CFG_TRIGGER_X: begin
          cfg.trigger_x <= cfg_data[stc_pkg::POS_BITS-1:0];
        end
        stc_pkg::CFG_TRIGGER_LEVEL: begin
          cfg.trigger_level <= cfg_data[stc_pkg::SAMPLE_BITS-1:0];
        end
        stc_pkg::CFG_TRIGGER_PREF: begin
          cfg.trigger_pref <= cfg_data[1:0];
        end
        stc_pkg::CFG_DISPLAY_MASK: begin
          cfg.display_mask <= cfg_data[2:0];
        end
        stc_pkg::CFG_NO_TRIGGER_LIMIT: begin
          cfg.no_trigger_limit <= cfg_data[stc_pkg::WAIT_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // input register feeds the update when the result register has room
  assign step     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= '{func: func, sample_a: sample_a, sample_b: sample_b, sample_c: sample_c,
                display_busy: display_busy, display_buf: display_buf};
    end
  end

  stc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign wr_en           = res_q.wr_en;
  assign wr_buf          = res_q.wr_buf;
  assign wr_pos          = res_q.wr_pos;
  assign wr_a            = res_q.wr_a;
  assign wr_b            = res_q.wr_b;
  assign wr_c            = res_q.wr_c;
  assign capturing_now   = res_q.capturing_now;
  assign capture_buf     = res_q.capture_buf;
  assign captured_count  = res_q.captured_count;
  assign offset_buf0     = res_q.offset_buf0;
  assign offset_buf1     = res_q.offset_buf1;
  assign no_trigger_swap = res_q.no_trigger_swap;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (wr_pos <= stc_pkg::POS_LAST && offset_buf0 <= stc_pkg::POS_LAST &&
                   offset_buf1 <= stc_pkg::POS_LAST))
    else $error("write position or draw offset out of buffer range");

  a_swap_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && no_trigger_swap) |-> (wr_en && !capturing_now && wr_buf != capture_buf))
    else $error("timeout swap without an idle write into the other buffer");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !wr_en) |-> (wr_pos == '0 && !no_trigger_swap))
    else $error("write fields set without a write");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !step) |=> (item_valid && $stable(item)))
    else $error("stalled item lost or changed in the input register");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for scope_trigger_capture_top, predicts each capture result
// depends on stc_pkg and scope_trigger_capture_top
// directed table first, then random phases under several register settings

module testbench;

  typedef struct packed {
    logic             known;
    stc_pkg::result_t res;
  } known_result_t;

  typedef struct packed {
    logic             new_cfg;
    stc_pkg::cfg_t    cfg;
    stc_pkg::item_t   it;
    logic             known;
    stc_pkg::result_t res;
  } row_t;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic                                  func = 1'b0;
  logic [stc_pkg::SAMPLE_BITS-1:0]       sample_a = '0;
  logic [stc_pkg::SAMPLE_BITS-1:0]       sample_b = '0;
  logic [stc_pkg::SAMPLE_BITS-1:0]       sample_c = '0;
  logic                                  display_busy = 1'b0;
  logic                                  display_buf = 1'b0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic                                  wr_en;
  logic                                  wr_buf;
  logic [stc_pkg::POS_BITS-1:0]          wr_pos;
  logic [stc_pkg::SAMPLE_BITS-1:0]       wr_a;
  logic [stc_pkg::SAMPLE_BITS-1:0]       wr_b;
  logic [stc_pkg::SAMPLE_BITS-1:0]       wr_c;
  logic                                  capturing_now;
  logic                                  capture_buf;
  logic signed [stc_pkg::COUNT_BITS-1:0] captured_count;
  logic [stc_pkg::POS_BITS-1:0]          offset_buf0;
  logic [stc_pkg::POS_BITS-1:0]          offset_buf1;
  logic                                  no_trigger_swap;
  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic [stc_pkg::INDEX_BITS-1:0]        cfg_index = '0;
  logic [stc_pkg::DATA_BITS-1:0]         cfg_data = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int mismatches = 0;

  // predictor state and register copy
  stc_pkg::cfg_t                         settings;
  logic                                  cap_active;
  logic                                  fill_buf;
  logic [stc_pkg::POS_BITS-1:0]          write_pos;
  logic [stc_pkg::WAIT_BITS-1:0]         wait_count;
  logic [stc_pkg::SAMPLE_BITS-1:0]       last_trig;
  logic [stc_pkg::POS_BITS-1:0]          draw_off [2];
  logic signed [stc_pkg::COUNT_BITS-1:0] cap_count [2];

  stc_pkg::result_t capture_results_due [$];
  known_result_t    known_results [$];

  scope_trigger_capture_top DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .func            (func),
    .sample_a        (sample_a),
    .sample_b        (sample_b),
    .sample_c        (sample_c),
    .display_busy    (display_busy),
    .display_buf     (display_buf),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .wr_en           (wr_en),
    .wr_buf          (wr_buf),
    .wr_pos          (wr_pos),
    .wr_a            (wr_a),
    .wr_b            (wr_b),
    .wr_c            (wr_c),
    .capturing_now   (capturing_now),
    .capture_buf     (capture_buf),
    .captured_count  (captured_count),
    .offset_buf0     (offset_buf0),
    .offset_buf1     (offset_buf1),
    .no_trigger_swap (no_trigger_swap),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic stc_pkg::result_t predict_capture(stc_pkg::item_t it);
    stc_pkg::result_t                r;
    stc_pkg::chan_t                  pref;
    stc_pkg::chan_t                  ch;
    logic [stc_pkg::SAMPLE_BITS-1:0] tsample;
    logic [stc_pkg::POS_BITS-1:0]    tx;
    logic                            free_ok;
    r = '0;
    if (it.func == stc_pkg::FUNC_RESTART) begin
      cap_active = 1'b0;
      write_pos = '0;
      wait_count = '0;
      last_trig = '0;
    end else begin
      pref = stc_pkg::chan_t'(settings.trigger_pref);
      if (pref == stc_pkg::CH_NONE) begin
        ch = stc_pkg::CH_NONE;
      end else if ((pref == stc_pkg::CH_C && settings.display_mask[2]) ||
                   settings.display_mask == 3'b100) begin
        ch = stc_pkg::CH_C;
      end else if ((pref == stc_pkg::CH_B || !settings.display_mask[0]) &&
                   settings.display_mask[1]) begin
        ch = stc_pkg::CH_B;
      end else begin
        ch = stc_pkg::CH_A;
      end
      tsample = (ch == stc_pkg::CH_A) ? it.sample_a :
                (ch == stc_pkg::CH_B) ? it.sample_b : it.sample_c;
      tx = (settings.trigger_x < stc_pkg::WIDTH) ? settings.trigger_x : stc_pkg::POS_LAST;
      free_ok = !it.display_busy || fill_buf != it.display_buf;

      if (!cap_active && free_ok &&
          (ch == stc_pkg::CH_NONE ||
           (wait_count > tx && last_trig < settings.trigger_level &&
            tsample >= settings.trigger_level))) begin
        cap_active = 1'b1;
        if (ch == stc_pkg::CH_NONE) begin
          write_pos = '0;
          draw_off[fill_buf] = '0;
          cap_count[fill_buf] = stc_pkg::COUNT_NONE;
        end else begin
          draw_off[fill_buf] = (write_pos >= tx) ? write_pos - tx
              : stc_pkg::POS_BITS'(write_pos + stc_pkg::WIDTH - tx);
          cap_count[fill_buf] = stc_pkg::COUNT_BITS'(tx - 1);
        end
      end

      if (cap_active && cap_count[fill_buf] == stc_pkg::COUNT_END) begin
        fill_buf = ~fill_buf;
        wait_count = '0;
        cap_active = 1'b0;
      end

      if (cap_active || !it.display_busy || fill_buf != it.display_buf) begin
        r.wr_en = 1'b1;
        r.wr_buf = fill_buf;
        r.wr_pos = write_pos;
        r.wr_a = it.sample_a;
        r.wr_b = it.sample_b;
        r.wr_c = it.sample_c;
        if (ch != stc_pkg::CH_NONE) last_trig = tsample;
        write_pos = (write_pos >= stc_pkg::POS_LAST) ? '0 : write_pos + 1'b1;
        if (cap_count[fill_buf] < stc_pkg::COUNT_MAX)
          cap_count[fill_buf] = cap_count[fill_buf] + stc_pkg::COUNT_BITS'(1);
        if (!cap_active) begin
          if (wait_count != stc_pkg::WAIT_MAX) wait_count = wait_count + 1'b1;
          if (wait_count > settings.no_trigger_limit && write_pos == '0) begin
            fill_buf = ~fill_buf;
            wait_count = '0;
            draw_off[fill_buf] = '0;
            r.no_trigger_swap = 1'b1;
          end
        end
      end
    end
    r.capturing_now = cap_active;
    r.capture_buf = fill_buf;
    r.captured_count = cap_count[fill_buf];
    r.offset_buf0 = draw_off[0];
    r.offset_buf1 = draw_off[1];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : monitor
    stc_pkg::item_t   cur;
    stc_pkg::result_t got;
    stc_pkg::result_t want;
    known_result_t    preset;
    if (rst) begin
      settings = '{trigger_x: 9'd160, trigger_level: 14'd8192, trigger_pref: stc_pkg::CH_A,
                   display_mask: 3'd7, no_trigger_limit: 24'd20000};
      cap_active = 1'b0;
      fill_buf = 1'b0;
      write_pos = '0;
      wait_count = '0;
      last_trig = '0;
      draw_off[0] = '0;
      draw_off[1] = '0;
      cap_count[0] = '0;
      cap_count[1] = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (stc_pkg::cfg_reg_t'(cfg_index))
          stc_pkg::CFG_TRIGGER_X:
            settings.trigger_x = cfg_data[stc_pkg::POS_BITS-1:0];
          stc_pkg::CFG_TRIGGER_LEVEL:
            settings.trigger_level = cfg_data[stc_pkg::SAMPLE_BITS-1:0];
          stc_pkg::CFG_TRIGGER_PREF:
            settings.trigger_pref = cfg_data[1:0];
          stc_pkg::CFG_DISPLAY_MASK:
            settings.display_mask = cfg_data[2:0];
          stc_pkg::CFG_NO_TRIGGER_LIMIT:
            settings.no_trigger_limit = cfg_data[stc_pkg::WAIT_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        cur.func = func;
        cur.sample_a = sample_a;
        cur.sample_b = sample_b;
        cur.sample_c = sample_c;
        cur.display_busy = display_busy;
        cur.display_buf = display_buf;
        preset = known_results.pop_front();
        want = predict_capture(cur);
        if (preset.known) want = preset.res;
        capture_results_due.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (capture_results_due.size() == 0) begin
          report_mismatch("result with none due", 0, 0);
        end else begin
          want = capture_results_due.pop_front();
          check_field("wr_en", wr_en, want.wr_en);
          check_field("wr_buf", wr_buf, want.wr_buf);
          check_field("wr_pos", wr_pos, want.wr_pos);
          check_field("wr_a", wr_a, want.wr_a);
          check_field("wr_b", wr_b, want.wr_b);
          check_field("wr_c", wr_c, want.wr_c);
          check_field("capturing_now", capturing_now, want.capturing_now);
          check_field("capture_buf", capture_buf, want.capture_buf);
          check_field("captured_count", captured_count, want.captured_count);
          check_field("offset_buf0", offset_buf0, want.offset_buf0);
          check_field("offset_buf1", offset_buf1, want.offset_buf1);
          check_field("no_trigger_swap", no_trigger_swap, want.no_trigger_swap);
        end
      end
    end
  end

  function automatic stc_pkg::cfg_t make_cfg(int x, int level, stc_pkg::chan_t pref, int mask,
                                             int limit);
    stc_pkg::cfg_t c;
    c.trigger_x = stc_pkg::POS_BITS'(x);
    c.trigger_level = stc_pkg::SAMPLE_BITS'(level);
    c.trigger_pref = pref;
    c.display_mask = 3'(mask);
    c.no_trigger_limit = stc_pkg::WAIT_BITS'(limit);
    return c;
  endfunction

  function automatic row_t make_row(stc_pkg::func_t f, int a, int b, int c, bit busy, bit dbuf);
    row_t r;
    r = '0;
    r.it.func = f;
    r.it.sample_a = stc_pkg::SAMPLE_BITS'(a);
    r.it.sample_b = stc_pkg::SAMPLE_BITS'(b);
    r.it.sample_c = stc_pkg::SAMPLE_BITS'(c);
    r.it.display_busy = busy;
    r.it.display_buf = dbuf;
    return r;
  endfunction

  function automatic logic [stc_pkg::SAMPLE_BITS-1:0] random_sample(bit quiet);
    int pick;
    pick = $urandom_range(9);
    if (quiet) return stc_pkg::SAMPLE_BITS'($urandom_range(16382));
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return stc_pkg::SAMPLE_BITS'($urandom_range(16383));
  endfunction

  task automatic write_reg(stc_pkg::cfg_reg_t idx, logic [stc_pkg::DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(stc_pkg::cfg_t c);
    write_reg(stc_pkg::CFG_TRIGGER_X, stc_pkg::DATA_BITS'(c.trigger_x));
    write_reg(stc_pkg::CFG_TRIGGER_LEVEL, stc_pkg::DATA_BITS'(c.trigger_level));
    write_reg(stc_pkg::CFG_TRIGGER_PREF, stc_pkg::DATA_BITS'(c.trigger_pref));
    write_reg(stc_pkg::CFG_DISPLAY_MASK, stc_pkg::DATA_BITS'(c.display_mask));
    write_reg(stc_pkg::CFG_NO_TRIGGER_LIMIT, stc_pkg::DATA_BITS'(c.no_trigger_limit));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (capture_results_due.size() != 0);
  endtask

  task automatic push_item(stc_pkg::item_t it, logic known, stc_pkg::result_t res);
    known_results.push_back('{known: known, res: res});
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= it.func;
    sample_a <= it.sample_a;
    sample_b <= it.sample_b;
    sample_c <= it.sample_c;
    display_busy <= it.display_busy;
    display_buf <= it.display_buf;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic run_phase(stc_pkg::cfg_t c, int n_items, bit quiet);
    stc_pkg::item_t it;
    drain_results();
    apply_settings(c);
    repeat (n_items) begin
      it.func = ($urandom_range(99) < 3) ? stc_pkg::FUNC_RESTART : stc_pkg::FUNC_SAMPLE;
      it.sample_a = random_sample(quiet);
      it.sample_b = random_sample(quiet);
      it.sample_c = random_sample(quiet);
      it.display_busy = ($urandom_range(99) < 30);
      it.display_buf = 1'($urandom_range(1));
      push_item(it, 1'b0, '0);
    end
  endtask

  initial begin
    row_t r;
    row_t directed_rows [$];

    r = make_row(stc_pkg::FUNC_RESTART, 16383, 16383, 16383, 1, 1);
    r.known = 1'b1;
    directed_rows.push_back(r);
    r = make_row(stc_pkg::FUNC_SAMPLE, 16383, 0, 16383, 0, 0);
    r.known = 1'b1;
    r.res.wr_en = 1'b1;
    r.res.wr_a = '1;
    r.res.wr_c = '1;
    r.res.captured_count = 12'sd1;
    directed_rows.push_back(r);
    r = make_row(stc_pkg::FUNC_SAMPLE, 0, 0, 0, 1, 0);
    r.known = 1'b1;
    r.res.captured_count = 12'sd1;
    directed_rows.push_back(r);
    r = make_row(stc_pkg::FUNC_SAMPLE, 0, 16383, 0, 1, 1);
    r.known = 1'b1;
    r.res.wr_en = 1'b1;
    r.res.wr_pos = 9'd1;
    r.res.wr_b = '1;
    r.res.captured_count = 12'sd2;
    directed_rows.push_back(r);
    // edge exactly at the level, then writes while drawing
    r = make_row(stc_pkg::FUNC_SAMPLE, 50, 1, 2, 0, 1);
    r.new_cfg = 1'b1;
    r.cfg = make_cfg(0, 100, stc_pkg::CH_A, 7, 24'hFFFFFF);
    directed_rows.push_back(r);
    directed_rows.push_back(make_row(stc_pkg::FUNC_SAMPLE, 100, 16383, 16383, 0, 0));
    directed_rows.push_back(make_row(stc_pkg::FUNC_SAMPLE, 16383, 0, 0, 1, 0));
    directed_rows.push_back(make_row(stc_pkg::FUNC_RESTART, 0, 0, 0, 0, 0));
    // trigger column past the buffer end, mask of C alone
    r = make_row(stc_pkg::FUNC_SAMPLE, 0, 0, 16383, 0, 1);
    r.new_cfg = 1'b1;
    r.cfg = make_cfg(400, 16383, stc_pkg::CH_B, 3'b100, 0);
    directed_rows.push_back(r);
    directed_rows.push_back(make_row(stc_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0));
    // free run
    r = make_row(stc_pkg::FUNC_SAMPLE, 1, 2, 3, 0, 0);
    r.new_cfg = 1'b1;
    r.cfg = make_cfg(0, 0, stc_pkg::CH_NONE, 0, 0);
    directed_rows.push_back(r);
    directed_rows.push_back(make_row(stc_pkg::FUNC_RESTART, 16383, 0, 16383, 1, 0));
    directed_rows.push_back(make_row(stc_pkg::FUNC_SAMPLE, 5, 5, 5, 1, 0));
    directed_rows.push_back(make_row(stc_pkg::FUNC_SAMPLE, 5, 5, 5, 1, 1));
    // A hidden selects B
    r = make_row(stc_pkg::FUNC_SAMPLE, 16383, 0, 16383, 0, 0);
    r.new_cfg = 1'b1;
    r.cfg = make_cfg(0, 8000, stc_pkg::CH_A, 3'b010, 1000);
    directed_rows.push_back(r);
    directed_rows.push_back(make_row(stc_pkg::FUNC_SAMPLE, 0, 9000, 0, 0, 0));
    // C preferred but hidden falls back to A
    r = make_row(stc_pkg::FUNC_SAMPLE, 16383, 0, 16383, 0, 1);
    r.new_cfg = 1'b1;
    r.cfg = make_cfg(319, 8192, stc_pkg::CH_C, 3'b011, 20000);
    directed_rows.push_back(r);
    // B preferred but hidden falls back to A
    r = make_row(stc_pkg::FUNC_SAMPLE, 9000, 16383, 0, 0, 0);
    r.new_cfg = 1'b1;
    r.cfg = make_cfg(1, 8192, stc_pkg::CH_B, 3'b001, 5);
    directed_rows.push_back(r);

    tx_idle_pct = 38;
    rx_idle_pct = 85;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].new_cfg) begin
        drain_results();
        apply_settings(directed_rows[i].cfg);
      end
      push_item(directed_rows[i].it, directed_rows[i].known, directed_rows[i].res);
    end

    run_phase(make_cfg(160, 8192, stc_pkg::CH_A, 7, 20000), 200, 1'b0);
    run_phase(make_cfg(5, 4000, stc_pkg::CH_B, 3'b010, 40), 100, 1'b0);
    tx_idle_pct = 85;
    rx_idle_pct = 38;
    run_phase(make_cfg(511, 16383, stc_pkg::CH_C, 3'b101, 0), 100, 1'b0);
    run_phase(make_cfg(0, 0, stc_pkg::CH_NONE, 0, 1000), 100, 1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // no crossing possible, idle writes only
    run_phase(make_cfg(0, 16383, stc_pkg::CH_A, 3'b110, 24'hFFFFFF), 60, 1'b1);
    run_phase(make_cfg(2, 8192, stc_pkg::CH_A, 3'b001, 300), 100, 1'b0);

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
